// File: hw/rtl/rmmsq_pkg.sv
// ---------------------------------------------------------------------------
// rmmsq_pkg
// Shared constants and controller/datapath handshake types for the range
// max/min segment tree block.
// ---------------------------------------------------------------------------
package rmmsq_pkg;

    localparam int LEAVES      = 1024;
    localparam int VALUE_BITS  = 16;
    localparam int LEAF_BITS   = $clog2(LEAVES);
    localparam int NODE_BITS   = LEAF_BITS + 1;
    localparam int NODES       = 2 * LEAVES;
    localparam int COUNT_BITS  = 11;
    localparam int COUNT_RESET = 1024;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic start;      // word accepted, latch request
        logic clr_step;   // clear one tree node
        logic upd_leaf;   // write leaf, fetch sibling
        logic upd_walk;   // write parent, fetch parent's sibling
        logic q_issue;    // issue one query level
        logic load_out;   // move result into output register
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic req_bad;
        logic req_query;
        logic root;
        logic q_last;
    } status_t;

endpackage

// File: hw/rtl/rmmsq_if.sv
// ---------------------------------------------------------------------------
// rmmsq_req_if / rmmsq_rsp_if
// Valid/ready channels for request and response words.
// ---------------------------------------------------------------------------
interface rmmsq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [rmmsq_pkg::LEAF_BITS-1:0]   position;
    logic [rmmsq_pkg::VALUE_BITS-1:0]  value;
    logic [rmmsq_pkg::LEAF_BITS-1:0]   query_start;
    logic [rmmsq_pkg::LEAF_BITS-1:0]   query_end;

    modport source (output valid, output opcode, output position, output value,
                    output query_start, output query_end, input ready);
    modport sink   (input valid, input opcode, input position, input value,
                    input query_start, input query_end, output ready);
endinterface

interface rmmsq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [rmmsq_pkg::VALUE_BITS-1:0]  range_max;
    logic [rmmsq_pkg::VALUE_BITS-1:0]  range_min;
    logic [rmmsq_pkg::VALUE_BITS-1:0]  spread;
    logic                              bad_request;

    modport source (output valid, output range_max, output range_min,
                    output spread, output bad_request, input ready);
    modport sink   (input valid, input range_max, input range_min,
                    input spread, input bad_request, output ready);
endinterface

// File: hw/rtl/rmmsq_ram.sv
// ---------------------------------------------------------------------------
// rmmsq_ram
// Generic RAM: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module rmmsq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: hw/rtl/rmmsq_ctrl.sv
// ---------------------------------------------------------------------------
// rmmsq_ctrl
// Sequencer: clearing pass, leaf update walk, query walk, result handoff.
// ---------------------------------------------------------------------------
module rmmsq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  rmmsq_pkg::status_t st,
    output rmmsq_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LEAF   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_QRY    = 3'd4;
    localparam logic [2:0] S_QDRAIN = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start = 1'b1;
                    if (st.req_bad)
                    begin
                        state_next = S_DONE;
                    end
                    else if (st.req_query)
                    begin
                        state_next = S_QRY;
                    end
                    else
                    begin
                        state_next = S_LEAF;
                    end
                end
            end
            S_LEAF:
            begin
                cmd.upd_leaf = 1'b1;
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                cmd.upd_walk = 1'b1;
                if (st.root)
                begin
                    state_next = S_DONE;
                end
            end
            S_QRY:
            begin
                cmd.q_issue = 1'b1;
                if (st.q_last)
                begin
                    state_next = S_QDRAIN;
                end
            end
            S_QDRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// File: hw/rtl/rmmsq_dp.sv
// ---------------------------------------------------------------------------
// rmmsq_dp
// Datapath: count register, max/min tree memories, update and query walks,
// result register.
// ---------------------------------------------------------------------------
module rmmsq_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rmmsq_pkg::COUNT_BITS-1:0]    cfg_data,
    input  logic                                opcode,
    input  logic [rmmsq_pkg::LEAF_BITS-1:0]     position,
    input  logic [rmmsq_pkg::VALUE_BITS-1:0]    value,
    input  logic [rmmsq_pkg::LEAF_BITS-1:0]     query_start,
    input  logic [rmmsq_pkg::LEAF_BITS-1:0]     query_end,
    input  rmmsq_pkg::cmd_t                     cmd,
    output rmmsq_pkg::status_t                  st,
    output logic [rmmsq_pkg::VALUE_BITS-1:0]    range_max,
    output logic [rmmsq_pkg::VALUE_BITS-1:0]    range_min,
    output logic [rmmsq_pkg::VALUE_BITS-1:0]    spread,
    output logic                                bad_request
);

    localparam int VB = rmmsq_pkg::VALUE_BITS;
    localparam int NB = rmmsq_pkg::NODE_BITS;
    localparam int CB = rmmsq_pkg::COUNT_BITS;
    localparam int RB = NB + 1;

    localparam logic [VB-1:0] ONES  = {VB{1'b1}};
    localparam logic [NB-1:0] ONE_N = NB'(1);

    function automatic logic [VB-1:0] vmax(input logic [VB-1:0] a, input logic [VB-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [VB-1:0] vmin(input logic [VB-1:0] a, input logic [VB-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [CB-1:0] count_reg;
    logic [NB-1:0] clr_addr_reg;
    logic          op_reg;
    logic          bad_reg;
    logic [NB-1:0] node_reg;
    logic [VB-1:0] cur_max_reg;
    logic [VB-1:0] cur_min_reg;
    logic [RB-1:0] l_reg;
    logic [RB-1:0] r_reg;
    logic [RB-1:0] l_next;
    logic [RB-1:0] r_next;
    logic          take_l_reg;
    logic          take_r_reg;
    logic [VB-1:0] acc_max_reg;
    logic [VB-1:0] acc_min_reg;
    logic [VB-1:0] acc_max_next;
    logic [VB-1:0] acc_min_next;
    logic [VB-1:0] out_max_reg;
    logic [VB-1:0] out_min_reg;
    logic [VB-1:0] out_spread_reg;
    logic          out_bad_reg;

    logic [CB-1:0] cnt_eff;
    logic          bad_now;
    logic [NB-1:0] parent;
    logic [VB-1:0] walk_max;
    logic [VB-1:0] walk_min;

    logic          we;
    logic [NB-1:0] waddr;
    logic [VB-1:0] wdata_max;
    logic [VB-1:0] wdata_min;
    logic [NB-1:0] raddr_a;
    logic [NB-1:0] raddr_b;
    logic [VB-1:0] rd_max_a;
    logic [VB-1:0] rd_max_b;
    logic [VB-1:0] rd_min_a;
    logic [VB-1:0] rd_min_b;

    assign cnt_eff = (count_reg > CB'(rmmsq_pkg::LEAVES)) ? CB'(rmmsq_pkg::LEAVES) : count_reg;

    always_comb
    begin
        if (opcode == rmmsq_pkg::OP_WRITE)
        begin
            bad_now = (CB'(position) >= cnt_eff);
        end
        else
        begin
            bad_now = (query_start > query_end) || (CB'(query_end) >= cnt_eff);
        end
    end

    assign parent   = node_reg >> 1;
    assign walk_max = vmax(cur_max_reg, rd_max_a);
    assign walk_min = vmin(cur_min_reg, rd_min_a);

    assign l_next = (l_reg + RB'(l_reg[0])) >> 1;
    assign r_next = r_reg >> 1;

    assign st.clr_last  = (clr_addr_reg == NB'(rmmsq_pkg::NODES - 1));
    assign st.req_bad   = bad_now;
    assign st.req_query = (opcode == rmmsq_pkg::OP_QUERY);
    assign st.root      = (parent == ONE_N);
    assign st.q_last    = !(l_next < r_next);

    // tree write port
    always_comb
    begin
        we        = 1'b0;
        waddr     = node_reg;
        wdata_max = cur_max_reg;
        wdata_min = cur_min_reg;
        priority if (cmd.clr_step)
        begin
            we        = 1'b1;
            waddr     = clr_addr_reg;
            wdata_max = '0;
            wdata_min = ONES;
        end
        else if (cmd.upd_leaf)
        begin
            we = 1'b1;
        end
        else if (cmd.upd_walk)
        begin
            we        = 1'b1;
            waddr     = parent;
            wdata_max = walk_max;
            wdata_min = walk_min;
        end
    end

    always_comb
    begin
        priority if (cmd.q_issue)
        begin
            raddr_a = l_reg[NB-1:0];
        end
        else if (cmd.upd_walk)
        begin
            raddr_a = parent ^ ONE_N;
        end
        else
        begin
            raddr_a = node_reg ^ ONE_N;
        end
    end

    assign raddr_b = {r_reg[NB-1:1], 1'b0};

    rmmsq_ram #(.WIDTH(VB), .DEPTH(rmmsq_pkg::NODES)) u_max_tree (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata_max),
        .raddr_a (raddr_a),
        .rdata_a (rd_max_a),
        .raddr_b (raddr_b),
        .rdata_b (rd_max_b)
    );

    rmmsq_ram #(.WIDTH(VB), .DEPTH(rmmsq_pkg::NODES)) u_min_tree (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata_min),
        .raddr_a (raddr_a),
        .rdata_a (rd_min_a),
        .raddr_b (raddr_b),
        .rdata_b (rd_min_b)
    );

    // query accumulate, one level behind the issue
    always_comb
    begin
        logic [VB-1:0] m1;
        logic [VB-1:0] n1;
        m1 = take_l_reg ? vmax(acc_max_reg, rd_max_a) : acc_max_reg;
        n1 = take_l_reg ? vmin(acc_min_reg, rd_min_a) : acc_min_reg;
        acc_max_next = take_r_reg ? vmax(m1, rd_max_b) : m1;
        acc_min_next = take_r_reg ? vmin(n1, rd_min_b) : n1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= CB'(rmmsq_pkg::COUNT_RESET);
            clr_addr_reg <= '0;
            take_l_reg   <= 1'b0;
            take_r_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + ONE_N;
            end
            take_l_reg <= cmd.q_issue & l_reg[0];
            take_r_reg <= cmd.q_issue & r_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg      <= opcode;
            bad_reg     <= bad_now;
            node_reg    <= NB'(position) + NB'(rmmsq_pkg::LEAVES);
            cur_max_reg <= value;
            cur_min_reg <= value;
            l_reg       <= RB'(query_start) + RB'(rmmsq_pkg::LEAVES);
            r_reg       <= RB'(query_end) + RB'(rmmsq_pkg::LEAVES) + RB'(1);
            acc_max_reg <= '0;
            acc_min_reg <= ONES;
        end
        else
        begin
            acc_max_reg <= acc_max_next;
            acc_min_reg <= acc_min_next;
            if (cmd.upd_walk)
            begin
                node_reg    <= parent;
                cur_max_reg <= walk_max;
                cur_min_reg <= walk_min;
            end
            if (cmd.q_issue)
            begin
                l_reg <= l_next;
                r_reg <= r_next;
            end
        end

        if (cmd.load_out)
        begin
            out_bad_reg <= bad_reg;
            if (bad_reg || (op_reg == rmmsq_pkg::OP_WRITE))
            begin
                out_max_reg    <= '0;
                out_min_reg    <= '0;
                out_spread_reg <= '0;
            end
            else
            begin
                out_max_reg    <= acc_max_reg;
                out_min_reg    <= acc_min_reg;
                out_spread_reg <= (acc_max_reg >= acc_min_reg) ? (acc_max_reg - acc_min_reg)
                                                              : '0;
            end
        end
    end

    assign range_max   = out_max_reg;
    assign range_min   = out_min_reg;
    assign spread      = out_spread_reg;
    assign bad_request = out_bad_reg;

endmodule

// File: hw/rtl/range_max_min_spread_query.sv
// ---------------------------------------------------------------------------
// range_max_min_spread_query
// Segment trees of range maxima and minima with point write and range query.
//
// req carries one word per item: opcode 0 writes value at position, opcode 1
// asks for max, min and spread over query_start..query_end. rsp returns one
// word per item; writes return zeros, rejected items return zeros with
// bad_request set. cfg_we/cfg_data load element_count; the user must do so
// only while the block idles, as the block itself does not enforce it.
// Items are handled one at a time. A write goes from the accepting idle
// state through a leaf step and a walk up to the root (11 tree levels
// written, one memory write and one sibling read per cycle) to a handoff
// state that loads the output register, from which rsp.valid is registered.
// A query issues one tree level per cycle, at most log2(LEAVES)+1 levels,
// then passes a drain state and the handoff; a rejected item goes straight
// from accept to the handoff. After reset all 2048 nodes of both tree
// memories are cleared one node a cycle, with req.ready low. When the
// receiver stalls, the result is held in the output register; one more item
// is accepted and worked, then holds until rsp is free.
// ---------------------------------------------------------------------------
module range_max_min_spread_query (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rmmsq_pkg::COUNT_BITS-1:0] cfg_data,
    rmmsq_req_if.sink                        req,
    rmmsq_rsp_if.source                      rsp
);

    rmmsq_pkg::cmd_t    cmd;
    rmmsq_pkg::status_t st;
    logic               req_ready;
    logic               rsp_valid;

    rmmsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    rmmsq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .opcode      (req.opcode),
        .position    (req.position),
        .value       (req.value),
        .query_start (req.query_start),
        .query_end   (req.query_end),
        .cmd         (cmd),
        .st          (st),
        .range_max   (rsp.range_max),
        .range_min   (rsp.range_min),
        .spread      (rsp.spread),
        .bad_request (rsp.bad_request)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !req_ready)
        else $error("request accepted during tree clear");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req_ready) |=> !req_ready)
        else $error("second word accepted while one is in flight");

    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.clr_step, cmd.upd_leaf, cmd.upd_walk, cmd.q_issue}))
        else $error("overlapping datapath operations");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid || rsp.ready))
        else $error("pending result overwritten");

endmodule
